// ----- rtl/core/pps_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_pkg
// Types, constants and control store for the preemptive priority scheduler.
// ---------------------------------------------------------------------------
package pps_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int TIME_W    = 16;
	localparam int SUM_W     = 20;
	localparam int PRI_W     = 8;
	localparam int TASK_W    = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] task_burst;
		logic [15:0] task_arrival;
		logic [7:0]  task_priority;
	} in_item_t;

	typedef struct packed {
		logic [15:0] tick_time;
		logic [3:0]  ran_task;
		logic        idle;
		logic        finished;
		logic [15:0] wait_time;
		logic [15:0] turnaround_time;
		logic [19:0] total_wait;
		logic [19:0] total_turnaround;
		logic        all_done;
		logic [4:0]  task_total;
	} out_item_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_WAIT = 3'd0;
	localparam step_t STEP_SCAN = 3'd1;
	localparam step_t STEP_UPD  = 3'd2;
	localparam step_t STEP_SUM  = 3'd3;
	localparam step_t STEP_EMIT = 3'd4;

	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_TICK     = 2'd1,
		COND_SCAN_END = 2'd2,
		COND_OUT_FREE = 2'd3
	} cond_t;

	typedef struct packed {
		logic  ready_en;
		logic  scan_en;
		logic  upd_en;
		logic  sum_en;
		logic  emit_en;
		cond_t cond;
		step_t target;
	} ctl_word_t;

	// control store: on a true condition go to target, else hold the step
	function automatic ctl_word_t ctl_rom(input step_t step);
		ctl_word_t w;
		w = '{ready_en: 1'b0, scan_en: 1'b0, upd_en: 1'b0, sum_en: 1'b0,
			emit_en: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
		case (step)
			STEP_WAIT: begin
				w.ready_en = 1'b1;
				w.cond     = COND_TICK;
				w.target   = STEP_SCAN;
			end
			STEP_SCAN: begin
				w.scan_en = 1'b1;
				w.cond    = COND_SCAN_END;
				w.target  = STEP_UPD;
			end
			STEP_UPD: begin
				w.upd_en = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_SUM;
			end
			STEP_SUM: begin
				w.sum_en = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_EMIT;
			end
			STEP_EMIT: begin
				w.emit_en = 1'b1;
				w.cond    = COND_OUT_FREE;
				w.target  = STEP_WAIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/pps_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_in_if
// Input channel: load and tick words with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pps_in_if import pps_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pps_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_out_if
// Output channel: one result word per tick with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pps_out_if import pps_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler
// Microcoded priority scheduler: a task table, a linear priority scan and
// per-tick bookkeeping of waiting and turnaround times.
// ---------------------------------------------------------------------------
// channel   dir   words
// in_ch     in    load task entry / advance one tick
// out_ch    out   one result per tick, none per load
//
// a load is taken in the wait step; a tick runs the scan, update, sum and emit
// steps in turn, the scan step reading one loaded table entry per cycle
// arst_n clears the step counter, counters, totals and the output valid
// the table has no reset; only entries below the load count are read
// a result waits in the output register; the emit step holds while it is full
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	pps_in_if.sink    in_ch,
	pps_out_if.source out_ch
);

	logic [15:0]      burst_q     [MAX_TASKS];
	logic [15:0]      arrival_q   [MAX_TASKS];
	logic [PRI_W-1:0] priority_q  [MAX_TASKS];
	logic [15:0]      remaining_q [MAX_TASKS];

	step_t            step_q;
	ctl_word_t        cw;
	logic [CNT_W-1:0] loaded_q;
	logic [CNT_W-1:0] done_q;
	logic [CNT_W-1:0] k_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] t_q;
	logic [SUM_W-1:0] wait_sum_q;
	logic [SUM_W-1:0] tat_sum_q;
	logic             found_q;
	logic [IDX_W-1:0] pick_q;
	logic [PRI_W-1:0] best_pri_q;
	logic             fin_q;
	logic [TIME_W-1:0] wait_q;
	logic [TIME_W-1:0] tat_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             in_fire;
	logic             out_free;
	logic             cond_ok;
	logic [IDX_W-1:0] rd_idx;
	logic             eligible;
	logic             better;
	logic [15:0]      ld_burst;
	logic [15:0]      rem_next;
	logic [TIME_W:0]  end_t;
	logic [TIME_W:0]  used_t;
	logic [TIME_W:0]  wait_raw;
	logic [TIME_W:0]  tat_raw;
	logic [SUM_W:0]   wait_add;
	logic [SUM_W:0]   tat_add;

	assign cw       = ctl_rom(step_q);
	assign in_fire  = in_ch.valid && cw.ready_en;
	assign out_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready  = cw.ready_en;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_comb begin
		case (cw.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_TICK:     cond_ok = in_fire && (in_ch.data.action == ACT_TICK);
			COND_SCAN_END: cond_ok = (k_q >= loaded_q);
			COND_OUT_FREE: cond_ok = out_free;
			default:       cond_ok = 1'b1;
		endcase
	end

	// one table read port, scan counter or picked task
	assign rd_idx   = cw.scan_en ? k_q[IDX_W-1:0] : pick_q;
	assign eligible = (arrival_q[rd_idx] <= t_q) && (remaining_q[rd_idx] != 16'd0);
	assign better   = !found_q || (priority_q[rd_idx] < best_pri_q);

	assign ld_burst = (in_ch.data.task_burst == 16'd0) ? 16'd1 : in_ch.data.task_burst;
	assign rem_next = remaining_q[rd_idx] - 16'd1;

	assign end_t    = {1'b0, t_q} + {{TIME_W{1'b0}}, 1'b1};
	assign used_t   = {1'b0, burst_q[rd_idx]} + {1'b0, arrival_q[rd_idx]};
	assign wait_raw = (end_t > used_t) ? end_t - used_t : '0;
	assign tat_raw  = (end_t > {1'b0, arrival_q[rd_idx]}) ?
		end_t - {1'b0, arrival_q[rd_idx]} : '0;

	assign wait_add = {1'b0, wait_sum_q} + {{(SUM_W-TIME_W+1){1'b0}}, wait_q};
	assign tat_add  = {1'b0, tat_sum_q} + {{(SUM_W-TIME_W+1){1'b0}}, tat_q};

	// task table
	always_ff @(posedge clk) begin
		if (in_fire && (in_ch.data.action == ACT_LOAD) &&
			(loaded_q < CNT_W'(MAX_TASKS)) && (now_q == '0)) begin
			burst_q[loaded_q[IDX_W-1:0]]     <= ld_burst;
			arrival_q[loaded_q[IDX_W-1:0]]   <= in_ch.data.task_arrival;
			priority_q[loaded_q[IDX_W-1:0]]  <= in_ch.data.task_priority;
			remaining_q[loaded_q[IDX_W-1:0]] <= ld_burst;
		end else if (cw.upd_en && found_q) begin
			remaining_q[rd_idx] <= rem_next;
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			t_q <= now_q;
		end
		if (cw.scan_en && !cond_ok && eligible && better) begin
			pick_q     <= k_q[IDX_W-1:0];
			best_pri_q <= priority_q[rd_idx];
		end
		if (cw.upd_en) begin
			fin_q <= found_q && (rem_next == 16'd0);
			if (found_q && (rem_next == 16'd0)) begin
				wait_q <= wait_raw[TIME_W] ? TIME_MAX : wait_raw[TIME_W-1:0];
				tat_q  <= tat_raw[TIME_W] ? TIME_MAX : tat_raw[TIME_W-1:0];
			end else begin
				wait_q <= '0;
				tat_q  <= '0;
			end
		end
		if (cw.emit_en && cond_ok) begin
			out_q.tick_time        <= t_q;
			out_q.ran_task         <= found_q ? TASK_W'(pick_q) : '0;
			out_q.idle             <= !found_q;
			out_q.finished         <= fin_q;
			out_q.wait_time        <= wait_q;
			out_q.turnaround_time  <= tat_q;
			out_q.total_wait       <= wait_sum_q;
			out_q.total_turnaround <= tat_sum_q;
			out_q.all_done         <= (done_q == loaded_q);
			out_q.task_total       <= loaded_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_WAIT;
			loaded_q    <= '0;
			done_q      <= '0;
			k_q         <= '0;
			now_q       <= '0;
			wait_sum_q  <= '0;
			tat_sum_q   <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cond_ok) begin
				step_q <= cw.target;
			end
			if (in_fire && (in_ch.data.action == ACT_LOAD) &&
				(loaded_q < CNT_W'(MAX_TASKS)) && (now_q == '0)) begin
				loaded_q <= loaded_q + 1'b1;
			end
			if (in_fire) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end
			if (cw.scan_en && !cond_ok) begin
				k_q <= k_q + 1'b1;
				if (eligible) begin
					found_q <= 1'b1;
				end
			end
			if (cw.sum_en) begin
				if (fin_q) begin
					done_q     <= done_q + 1'b1;
					wait_sum_q <= wait_add[SUM_W] ? SUM_MAX : wait_add[SUM_W-1:0];
					tat_sum_q  <= tat_add[SUM_W] ? SUM_MAX : tat_add[SUM_W-1:0];
				end
				if (now_q != TIME_MAX) begin
					now_q <= now_q + 1'b1;
				end
			end
			if (cw.emit_en && cond_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
